[rtl/keyed_slot_table_macros.svh]
// Assertion macros for the table RTL.
`ifndef KEYED_SLOT_TABLE_MACROS_SVH
`define KEYED_SLOT_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KST_ASSERT(lbl, clk, rstn, prop, msg)
`define KST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/kst_pkg.sv]
package kst_pkg;

  localparam int REQ_W  = 3;
  localparam int KEY_W  = 31;
  localparam int HDL_W  = 32;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd32;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CMP_KEY,
    OP_CMP_OCC,
    OP_INSERT,
    OP_MODIFY,
    OP_FREE,
    OP_MARK
  } cell_op_e;

  // Broadcast to every cell.
  typedef struct packed {
    cell_op_e           op;
    logic               src_mark;
    logic [KEY_W-1:0]   key;
    logic [HDL_W-1:0]   hdl;
  } kst_cmd_t;

  // Passed from each cell to the next one up.
  typedef struct packed {
    logic               taken;
    logic               occ;
    logic [HDL_W-1:0]   hdl;
  } kst_link_t;

endpackage

[rtl/kst_cell.sv]
module kst_cell
  import kst_pkg::*;
#(
  parameter int IdxW = 5,
  parameter int Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kst_cmd_t        cmd_i,
  input  kst_link_t       link_i,
  output kst_link_t       link_o,
  input  logic [IdxW-1:0] idx_i,
  output logic [IdxW-1:0] idx_o,
  output logic            sel_o,
  output logic            mark_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [HDL_W-1:0] hdl_q, hdl_d;
  logic             hit_q, hit_d;
  logic             mark_q, mark_d;
  logic             cand;
  logic             sel;

  // Lowest candidate wins: a lower cell that is a candidate takes the chain.
  assign cand = cmd_i.src_mark ? mark_q : hit_q;
  assign sel  = cand & ~link_i.taken;

  always_comb begin
    key_d  = key_q;
    hdl_d  = hdl_q;
    hit_d  = hit_q;
    mark_d = mark_q;
    case (cmd_i.op)
      OP_CMP_KEY: hit_d = (key_q == cmd_i.key);
      OP_CMP_OCC: hit_d = (key_q != '0);
      OP_INSERT: begin
        if (sel) begin
          key_d = cmd_i.key;
          hdl_d = cmd_i.hdl;
        end
      end
      OP_MODIFY: begin
        if (sel) hdl_d = cmd_i.hdl;
      end
      OP_FREE: begin
        if (sel) begin
          key_d  = '0;
          hdl_d  = '0;
          mark_d = 1'b0;
        end
      end
      OP_MARK: begin
        if (sel) begin
          hit_d  = 1'b0;
          mark_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign link_o.taken = link_i.taken | cand;
  assign link_o.occ   = link_i.occ | (key_d != '0);
  assign link_o.hdl   = link_i.hdl | (sel ? hdl_q : '0);
  assign idx_o        = idx_i | (sel ? IdxW'(Idx) : '0);
  assign sel_o        = sel;
  assign mark_o       = mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      hdl_q  <= '0;
      hit_q  <= 1'b0;
      mark_q <= 1'b0;
    end else begin
      key_q  <= key_d;
      hdl_q  <= hdl_d;
      hit_q  <= hit_d;
      mark_q <= mark_d;
    end
  end

endmodule

[rtl/keyed_slot_table.sv]
// Keyed slot table: TABLE_DEPTH slots, each a key and a handle word; key zero
// means free.
// Request channel: in_valid_i/in_ready_o with req_type_i, req_key_i and
// handle_i. Result channel: out_valid_o/out_ready_i with ok_o, slot_o,
// table_empty_o, released_handle_o, released_valid_o and last_o.
// Insert, modify, remove, lookup and unknown requests compare the key in every
// slot cell on accept; then, once the result register is free, they pick the
// lowest hit through the cell chain, update that cell and load the result.
// Clear is accepted, then a marking pass picks one slot per cycle through the
// chain (at most 32 slots), then one result is given per freed slot; an empty
// table gives a single result.
// One request is in work at a time; in_ready_o is high only between requests.
// The result register lets a request be accepted while the last result still
// waits. When the receiver stalls, the block holds the result and waits.
// Reset frees every slot at once and leaves both channels empty.
`include "keyed_slot_table_macros.svh"

module keyed_slot_table
  import kst_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [KEY_W-1:0]  req_key_i,
  input  logic [HDL_W-1:0]  handle_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              table_empty_o,
  output logic [HDL_W-1:0]  released_handle_o,
  output logic              released_valid_o,
  output logic              last_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_APPLY = 3'd1;
  localparam logic [2:0] ST_CPRE  = 3'd2;
  localparam logic [2:0] ST_CEMIT = 3'd3;

  logic [2:0]       state_q, state_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [HDL_W-1:0] hdl_q, hdl_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             empty_q, empty_d;

  logic              out_valid_q, out_valid_d;
  logic              ok_q, ok_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              tempty_q, tempty_d;
  logic [HDL_W-1:0]  rel_q, rel_d;
  logic              last_q, last_d;

  kst_cmd_t         cmd;
  kst_link_t        link [TABLE_DEPTH+1];
  logic [IdxW-1:0]  idx_chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] sel_vec;
  logic [TABLE_DEPTH-1:0] mark_vec;

  logic found;
  logic out_free;
  logic load;

  assign link[0]      = '0;
  assign idx_chain[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kst_cell #(
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .link_i (link[g]),
      .link_o (link[g+1]),
      .idx_i  (idx_chain[g]),
      .idx_o  (idx_chain[g+1]),
      .sel_o  (sel_vec[g]),
      .mark_o (mark_vec[g])
    );
  end

  assign found    = link[TABLE_DEPTH].taken;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    key_d      = key_q;
    hdl_d      = hdl_q;
    cnt_d      = cnt_q;
    empty_d    = empty_q;
    in_ready_o = 1'b0;
    load       = 1'b0;
    ok_d       = 1'b0;
    slot_d     = '0;
    tempty_d   = empty_q;
    rel_d      = '0;
    last_d     = 1'b1;

    cmd.op       = OP_NONE;
    cmd.src_mark = 1'b0;
    cmd.key      = key_q;
    cmd.hdl      = hdl_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // Insert hunts for a free slot, i.e. key zero.
          cmd.op  = (req_type_i == REQ_CLEAR) ? OP_CMP_OCC : OP_CMP_KEY;
          cmd.key = (req_type_i == REQ_INSERT) ? '0 : req_key_i;
          req_d   = req_type_i;
          key_d   = req_key_i;
          hdl_d   = handle_i;
          cnt_d   = '0;
          state_d = (req_type_i == REQ_CLEAR) ? ST_CPRE : ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
          if (found && (req_q < REQ_CLEAR)) begin
            ok_d   = 1'b1;
            slot_d = SLOT_W'(idx_chain[TABLE_DEPTH]);
            case (req_q)
              REQ_INSERT: cmd.op = OP_INSERT;
              REQ_MODIFY: cmd.op = OP_MODIFY;
              REQ_REMOVE: begin
                cmd.op = OP_FREE;
                rel_d  = link[TABLE_DEPTH].hdl;
              end
              default: cmd.op = OP_NONE;
            endcase
          end
          tempty_d = !link[TABLE_DEPTH].occ;
        end
      end
      ST_CPRE: begin
        // Mark up to MAX_RESULTS occupied slots, lowest first.
        if ((cnt_q == MAX_RESULTS) || !found) begin
          empty_d = !found;
          state_d = ST_CEMIT;
        end else begin
          cmd.op = OP_MARK;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      ST_CEMIT: begin
        cmd.src_mark = 1'b1;
        if (out_free) begin
          load = 1'b1;
          if (cnt_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cmd.op = OP_FREE;
            ok_d   = 1'b1;
            slot_d = SLOT_W'(idx_chain[TABLE_DEPTH]);
            rel_d  = link[TABLE_DEPTH].hdl;
            last_d = (cnt_q == CNT_W'(1));
            cnt_d  = cnt_q - 1'b1;
            if (cnt_q == CNT_W'(1)) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    key_q   <= key_d;
    hdl_q   <= hdl_d;
    empty_q <= empty_d;
    if (load) begin
      ok_q     <= ok_d;
      slot_q   <= slot_d;
      tempty_q <= tempty_d;
      rel_q    <= rel_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign slot_o            = slot_q;
  assign table_empty_o     = tempty_q;
  assign released_handle_o = rel_q;
  assign released_valid_o  = (rel_q != '0);
  assign last_o            = last_q;

  `KST_ASSERT(a_sel_onehot, clk_i, rst_ni, $onehot0(sel_vec), "more than one cell selected")
  `KST_ASSERT(a_idle_no_mark, clk_i, rst_ni, (state_q == ST_IDLE) |-> (mark_vec == '0), "mark left behind after clear")
  `KST_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= MAX_RESULTS, "clear count out of range")
  `KST_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE), "accepted word not taken up")

endmodule

[dv/testbench.sv]
module testbench;
  import kst_pkg::*;

  localparam int DEPTH       = 32;
  localparam int ITEM_TARGET = 220;
  localparam int QUIET_FROM  = 120;
  localparam int QUIET_TO    = 165;

  localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  localparam logic [KEY_W-1:0] KEY_NONE = '0;
  localparam logic [KEY_W-1:0] KEY_TOP  = '1;
  localparam logic [HDL_W-1:0] HDL_NONE = '0;
  localparam logic [HDL_W-1:0] HDL_TOP  = '1;

  typedef struct {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              tbl_empty;
    logic [HDL_W-1:0]  rel_hdl;
    logic              rel_valid;
    logic              last;
  } result_word_t;

  class slot_table_ledger;
    logic [KEY_W-1:0] keys [DEPTH];
    logic [HDL_W-1:0] hdls [DEPTH];
    result_word_t     expected_q [$];
    int               fail_count;
    int               results_seen;
    int               full_hits;
    int               req_count [8];

    function new();
      foreach (keys[i]) begin
        keys[i] = '0;
        hdls[i] = '0;
      end
      foreach (req_count[i]) req_count[i] = 0;
      fail_count    = 0;
      results_seen  = 0;
      full_hits     = 0;
    endfunction

    function bit none_occupied();
      foreach (keys[i]) if (keys[i] != '0) return 1'b0;
      return 1'b1;
    endfunction

    function int lowest_match(logic [KEY_W-1:0] key);
      foreach (keys[i]) if (keys[i] == key) return i;
      return -1;
    endfunction

    // Call only after the table update, so the empty flag reflects it.
    function void push_result(bit ok, int slot, logic [HDL_W-1:0] rel, bit last);
      result_word_t r;
      r.ok        = ok;
      r.slot      = slot[SLOT_W-1:0];
      r.tbl_empty = none_occupied();
      r.rel_hdl   = rel;
      r.rel_valid = (rel != '0);
      r.last      = last;
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                               logic [HDL_W-1:0] hdl);
      int               idx;
      int               i;
      int               freed [$];
      logic [HDL_W-1:0] rel [$];
      logic [KEY_W-1:0] probe;
      logic [HDL_W-1:0] out_hdl;
      req_count[req]++;
      if (req == REQ_CLEAR) begin
        for (i = 0; i < DEPTH && freed.size() < int'(MAX_RESULTS); i++) begin
          if (keys[i] != '0) begin
            freed.push_back(i);
            rel.push_back(hdls[i]);
            keys[i] = '0;
            hdls[i] = '0;
          end
        end
        if (freed.size() == 0) begin
          push_result(1'b0, 0, HDL_NONE, 1'b1);
        end else begin
          foreach (freed[k]) push_result(1'b1, freed[k], rel[k], k == freed.size() - 1);
        end
        return;
      end
      if (req > REQ_CLEAR) begin
        push_result(1'b0, 0, HDL_NONE, 1'b1);
        return;
      end
      // Insert hunts for a free slot, everything else for the key.
      probe = (req == REQ_INSERT) ? KEY_NONE : key;
      idx = lowest_match(probe);
      if (idx < 0) begin
        if (req == REQ_INSERT) full_hits++;
        push_result(1'b0, 0, HDL_NONE, 1'b1);
        return;
      end
      out_hdl = HDL_NONE;
      case (req)
        REQ_INSERT: begin
          keys[idx] = key;
          hdls[idx] = hdl;
        end
        REQ_MODIFY: hdls[idx] = hdl;
        REQ_REMOVE: begin
          out_hdl   = hdls[idx];
          keys[idx] = '0;
          hdls[idx] = '0;
        end
        default: ;
      endcase
      push_result(1'b1, idx, out_hdl, 1'b1);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic ok, logic [SLOT_W-1:0] slot, logic tbl_empty,
                               logic [HDL_W-1:0] rel_hdl, logic rel_valid, logic last);
      result_word_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual ok=%0b slot=%0d",
                 $time, ok, slot);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("ok", want.ok, ok);
      compare_field("slot", want.slot, slot);
      compare_field("table_empty", want.tbl_empty, tbl_empty);
      compare_field("released_handle", want.rel_hdl, rel_hdl);
      compare_field("released_valid", want.rel_valid, rel_valid);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [REQ_W-1:0]  req_type  = REQ_LOOKUP;
  logic [KEY_W-1:0]  req_key   = '0;
  logic [HDL_W-1:0]  handle    = '0;
  logic              out_ready = 1'b0;
  logic              quiet     = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              ok;
  logic [SLOT_W-1:0] slot;
  logic              table_empty;
  logic [HDL_W-1:0]  released_handle;
  logic              released_valid;
  logic              last;

  logic [KEY_W-1:0]  key_pool [8];
  int                sent = 0;
  int                clear_words = 0;

  slot_table_ledger ledger = new();

  keyed_slot_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .req_key_i        (req_key),
    .handle_i         (handle),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .ok_o             (ok),
    .slot_o           (slot),
    .table_empty_o    (table_empty),
    .released_handle_o(released_handle),
    .released_valid_o (released_valid),
    .last_o           (last)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_result(ok, slot, table_empty, released_handle, released_valid, last);
    end
  end

  // Hold valid across back-to-back words; drop it only when idling.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                              input logic [HDL_W-1:0] hdl);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    req_key  <= key;
    handle   <= hdl;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    ledger.note_request(req, key, hdl);
    sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return key_pool[$urandom_range(7)];
    if (roll < 95) return KEY_W'($urandom);
    return KEY_NONE;
  endfunction

  function automatic logic [HDL_W-1:0] pick_handle();
    if ($urandom_range(9) == 0) return HDL_NONE;
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return REQ_INSERT;
    if (roll < 50) return REQ_MODIFY;
    if (roll < 70) return REQ_REMOVE;
    if (roll < 85) return REQ_LOOKUP;
    if (roll < 92) return REQ_CLEAR;
    return REQ_W'($urandom_range(REQ_RSVD_7, REQ_RSVD_5));
  endfunction

  // Overfill the table by two, then clear it in one long burst of results.
  task automatic fill_table();
    repeat (DEPTH + 2)
      send_request(REQ_INSERT, KEY_W'($urandom_range(32'h7FFF_FFFF, 1)), pick_handle());
    send_request(REQ_LOOKUP, key_pool[$urandom_range(7)], pick_handle());
    send_request(REQ_CLEAR, pick_key(), pick_handle());
  endtask

  initial begin
    int roll;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(32'h7FFF_FFFF, 1));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(REQ_LOOKUP, 31'd5, $urandom);
    send_request(REQ_CLEAR, KEY_W'($urandom), $urandom);
    send_request(REQ_RSVD_5, KEY_W'($urandom), $urandom);
    send_request(REQ_RSVD_6, KEY_W'($urandom), $urandom);
    send_request(REQ_RSVD_7, KEY_TOP, HDL_TOP);
    send_request(REQ_INSERT, KEY_TOP, HDL_TOP);
    send_request(REQ_INSERT, 31'd1, HDL_NONE);
    // Key zero stores a handle but leaves the slot free.
    send_request(REQ_INSERT, KEY_NONE, 32'hA5A5_5A5A);
    send_request(REQ_LOOKUP, KEY_NONE, HDL_NONE);
    send_request(REQ_MODIFY, KEY_TOP, 32'h1234_5678);
    send_request(REQ_MODIFY, 31'd77, HDL_TOP);
    send_request(REQ_LOOKUP, KEY_TOP, HDL_NONE);
    send_request(REQ_REMOVE, KEY_NONE, HDL_NONE);
    send_request(REQ_REMOVE, 31'd1, HDL_NONE);
    send_request(REQ_REMOVE, KEY_TOP, HDL_NONE);
    send_request(REQ_LOOKUP, KEY_TOP, HDL_NONE);
    send_request(REQ_REMOVE, 31'd77, HDL_NONE);
    send_request(REQ_INSERT, key_pool[0], $urandom);
    send_request(REQ_INSERT, key_pool[1], HDL_NONE);
    send_request(REQ_INSERT, key_pool[2], $urandom);
    send_request(REQ_LOOKUP, key_pool[1], HDL_NONE);
    send_request(REQ_CLEAR, KEY_NONE, HDL_NONE);
    send_request(REQ_LOOKUP, key_pool[0], HDL_NONE);
    hold_until_drained();
    fill_table();

    while (sent < ITEM_TARGET) begin
      quiet = (sent >= QUIET_FROM && sent < QUIET_TO);
      roll = $urandom_range(99);
      if (roll < 2 && sent < ITEM_TARGET - 40) begin
        fill_table();
      end else if (roll < 4) begin
        hold_until_drained();
      end else begin
        send_request(pick_req(), pick_key(), pick_handle());
      end
    end
    quiet = 1'b0;
    hold_until_drained();
    repeat (20) @(posedge clk);

    clear_words = ledger.req_count[REQ_CLEAR];
    $display("Sent %0d requests: %0d insert, %0d modify, %0d remove, %0d lookup, %0d clear",
             sent, ledger.req_count[REQ_INSERT], ledger.req_count[REQ_MODIFY],
             ledger.req_count[REQ_REMOVE], ledger.req_count[REQ_LOOKUP], clear_words);
    $display("Checked %0d result words; inserts refused on a full table: %0d",
             ledger.results_seen, ledger.full_hits);
    if (ledger.fail_count == 0) begin
      $display("PASS keyed_slot_table");
    end else begin
      $display("FAIL keyed_slot_table");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL keyed_slot_table");
    $finish;
  end

endmodule
